// ----- rtl/core/nialu_pkg.sv -----
// Package with opcode, status and pipeline types for the null-aware integer ALU.
`timescale 1ns / 1ps
package nialu_pkg;

	typedef enum logic [4:0] {
		OP_LAND = 5'd0, OP_LOR = 5'd1, OP_LXOR = 5'd2,
		OP_ADD = 5'd3, OP_SUB = 5'd4, OP_MUL = 5'd5,
		OP_IDIV = 5'd6, OP_REM = 5'd7, OP_POW = 5'd8,
		OP_EQ = 5'd9, OP_NE = 5'd10, OP_LE = 5'd11, OP_LT = 5'd12,
		OP_GE = 5'd13, OP_GT = 5'd14, OP_MIN = 5'd15, OP_MAX = 5'd16,
		OP_BAND = 5'd17, OP_BOR = 5'd18, OP_BXOR = 5'd19
	} opcode_t;

	localparam logic [4:0] OP_LAST = 5'd19;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_DIVZERO = 2'd1, ST_FLOAT = 2'd2, ST_BADOP = 2'd3
	} status_t;

	// Kind of work an item needs after decode.
	typedef enum logic [1:0] {
		K_DONE = 2'd0, K_MUL = 2'd1, K_DIV = 2'd2, K_POW = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t        kind;
		logic         is_rem;
		logic         neg_q;
		logic         neg_r;
		logic [31:0]  value;
		logic         is_null;
		status_t      status;
	} decode_t;

	// Largest |a| for which a^e fits in 32 signed bits, for e from 2 to 30.
	function automatic logic [15:0] pow_limit(input logic [4:0] e);
		logic [15:0] r;
		unique case (e)
			5'd2: r = 16'd46340;
			5'd3: r = 16'd1290;
			5'd4: r = 16'd215;
			5'd5: r = 16'd73;
			5'd6: r = 16'd35;
			5'd7: r = 16'd21;
			5'd8: r = 16'd14;
			5'd9: r = 16'd10;
			5'd10: r = 16'd8;
			5'd11: r = 16'd7;
			5'd12, 5'd13: r = 16'd5;
			5'd14, 5'd15: r = 16'd4;
			5'd16, 5'd17, 5'd18, 5'd19: r = 16'd3;
			default: r = 16'd2;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/core/nialu_decode.sv -----
// Operand decode: logic, compare, add, subtract, min/max and bitwise results plus setup for long operations.
`timescale 1ns / 1ps
module nialu_decode (
	input  logic [4:0]          opcode,
	input  logic [31:0]         a_value,
	input  logic                a_null,
	input  logic [31:0]         b_value,
	input  logic                b_null,
	output nialu_pkg::decode_t  dec
);
	import nialu_pkg::*;

	logic ta, tb, lt_ab, lt_ba, a_neg, b_neg;
	logic [15:0] lim;
	logic [31:0] ma;

	always_comb begin
		ta = (a_value != 32'd0);
		tb = (b_value != 32'd0);
		a_neg = a_value[31];
		b_neg = b_value[31];
		lt_ab = $signed(a_value) < $signed(b_value);
		lt_ba = $signed(b_value) < $signed(a_value);
		ma = a_neg ? (32'd0 - a_value) : a_value;
		lim = pow_limit(b_value[4:0]);
		dec = '0;
		dec.kind = K_DONE;
		dec.status = ST_OK;
		if (opcode <= OP_LXOR) begin
			unique case (opcode)
				OP_LAND: begin
					if ((!a_null && !ta) || (!b_null && !tb)) dec.value = 32'd0;
					else if (a_null || b_null) dec.is_null = 1'b1;
					else dec.value = 32'd1;
				end
				OP_LOR: begin
					if ((!a_null && ta) || (!b_null && tb)) dec.value = 32'd1;
					else if (a_null || b_null) dec.is_null = 1'b1;
					else dec.value = 32'd0;
				end
				default: begin
					if (a_null || b_null) dec.is_null = 1'b1;
					else dec.value = {31'd0, ta ^ tb};
				end
			endcase
		end else if (opcode > OP_LAST) begin
			dec.status = ST_BADOP;
		end else if (a_null || b_null) begin
			dec.is_null = 1'b1;
		end else begin
			unique case (opcode)
				OP_ADD: dec.value = a_value + b_value;
				OP_SUB: dec.value = a_value - b_value;
				OP_MUL: dec.kind = K_MUL;
				OP_IDIV, OP_REM: begin
					if (b_value == 32'd0) dec.status = ST_DIVZERO;
					else begin
						dec.kind = K_DIV;
						dec.is_rem = (opcode == OP_REM);
						dec.neg_q = a_neg ^ b_neg;
						dec.neg_r = a_neg;
					end
				end
				OP_POW: begin
					if (b_value == 32'd0) dec.value = 32'd1;
					else if (b_neg) dec.status = ST_FLOAT;
					else if (a_value == 32'd0 || a_value == 32'd1) dec.value = a_value;
					else if (a_value == 32'hFFFF_FFFF)
						dec.value = b_value[0] ? 32'hFFFF_FFFF : 32'd1;
					else if (b_value == 32'd1) dec.value = a_value;
					else if (b_value > 32'd30) dec.status = ST_FLOAT;
					else if (ma > {16'd0, lim}) dec.status = ST_FLOAT;
					else dec.kind = K_POW;
				end
				OP_EQ: dec.value = {31'd0, a_value == b_value};
				OP_NE: dec.value = {31'd0, a_value != b_value};
				OP_LE: dec.value = {31'd0, !lt_ba};
				OP_LT: dec.value = {31'd0, lt_ab};
				OP_GE: dec.value = {31'd0, !lt_ab};
				OP_GT: dec.value = {31'd0, lt_ba};
				OP_MIN: dec.value = lt_ab ? a_value : b_value;
				OP_MAX: dec.value = lt_ba ? a_value : b_value;
				OP_BAND: dec.value = a_value & b_value;
				OP_BOR: dec.value = a_value | b_value;
				default: dec.value = a_value ^ b_value;
			endcase
		end
	end
endmodule

// ----- rtl/core/nialu_divstep.sv -----
// One restoring divide step on magnitudes: shifts in one dividend bit.
`timescale 1ns / 1ps
module nialu_divstep (
	input  logic [31:0] rem_in,
	input  logic [31:0] quo_in,
	input  logic [31:0] divisor,
	output logic [31:0] rem_out,
	output logic [31:0] quo_out
);
	logic [32:0] trial;

	always_comb begin
		trial = {rem_in, quo_in[31]};
		if (trial >= {1'b0, divisor}) begin
			trial = trial - {1'b0, divisor};
			quo_out = {quo_in[30:0], 1'b1};
		end else begin
			quo_out = {quo_in[30:0], 1'b0};
		end
		rem_out = trial[31:0];
	end
endmodule

// ----- rtl/core/null_aware_integer_alu.sv -----
// Top level of the null-aware integer ALU: decode stage, 32 divide/power stages, output stage.
`timescale 1ns / 1ps
// Channel   Dir  Fields (tdata from bit 0 up)
// s_axis    in   tdata: opcode[4:0] a_value[36:5] a_null[37] b_value[69:38] b_null[70], pad to 72
// m_axis    out  tdata: result_value[31:0] result_null[32] status[34:33], pad to 40
// Every item passes through one decode stage, 32 stages that each
// carry one divide bit or one power multiplication, and the output register.
// A new transaction can enter every cycle; the pipeline advances only when the output
// register is empty or being taken, so a stall holds every stage in place.
// Reset clears only the valid bits.
module null_aware_integer_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // opcode, a_value, a_null, b_value, b_null
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // result_value, result_null, status
);
	import nialu_pkg::*;

	localparam int Steps = 32;

	decode_t     dec;
	logic        adv;
	logic [Steps:0] v_s;
	decode_t     d_s   [Steps+1];
	logic [31:0] rem_s [Steps+1];
	logic [31:0] quo_s [Steps+1];
	logic [31:0] dvs_s [Steps+1];
	logic [4:0]  cnt_s [Steps+1];
	logic [31:0] rem_n [Steps];
	logic [31:0] quo_n [Steps];
	logic [31:0] res_q;
	logic        null_q;
	status_t     st_q;
	logic        vld_q;
	logic [31:0] fin;

	nialu_decode u_dec (
		.opcode (s_axis_tdata[4:0]),
		.a_value(s_axis_tdata[36:5]),
		.a_null (s_axis_tdata[37]),
		.b_value(s_axis_tdata[69:38]),
		.b_null (s_axis_tdata[70]),
		.dec    (dec)
	);

	assign adv = !vld_q || m_axis_tready;
	assign s_axis_tready = adv;

	// Stage 0 register: rem_s holds the running power, quo_s the magnitude dividend or the power base.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else if (adv) v_s[0] <= s_axis_tvalid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			d_s[0] <= dec;
			if (dec.kind == K_POW) begin
				rem_s[0] <= 32'd1;
				quo_s[0] <= s_axis_tdata[36:5];
				dvs_s[0] <= s_axis_tdata[36:5];
				cnt_s[0] <= s_axis_tdata[42:38];
			end else if (dec.kind == K_MUL) begin
				rem_s[0] <= 32'd0;
				quo_s[0] <= s_axis_tdata[36:5];
				dvs_s[0] <= s_axis_tdata[69:38];
				cnt_s[0] <= 5'd0;
			end else begin
				rem_s[0] <= 32'd0;
				quo_s[0] <= s_axis_tdata[36] ? 32'd0 - s_axis_tdata[36:5] : s_axis_tdata[36:5];
				dvs_s[0] <= s_axis_tdata[69] ? 32'd0 - s_axis_tdata[69:38]
					: s_axis_tdata[69:38];
				cnt_s[0] <= 5'd0;
			end
		end
	end

	genvar g;
	generate
		for (g = 0; g < Steps; g++) begin : g_step
			nialu_divstep u_step (
				.rem_in (rem_s[g]),
				.quo_in (quo_s[g]),
				.divisor(dvs_s[g]),
				.rem_out(rem_n[g]),
				.quo_out(quo_n[g])
			);
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) v_s[g+1] <= 1'b0;
				else if (adv) v_s[g+1] <= v_s[g];
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					d_s[g+1] <= d_s[g];
					dvs_s[g+1] <= dvs_s[g];
					unique case (d_s[g].kind)
						K_DIV: begin
							rem_s[g+1] <= rem_n[g];
							quo_s[g+1] <= quo_n[g];
							cnt_s[g+1] <= cnt_s[g];
						end
						K_POW: begin
							// One multiplication per stage while exponent remains.
							rem_s[g+1] <= (cnt_s[g] != 5'd0) ? rem_s[g] * quo_s[g] : rem_s[g];
							quo_s[g+1] <= quo_s[g];
							cnt_s[g+1] <= (cnt_s[g] != 5'd0) ? cnt_s[g] - 5'd1 : 5'd0;
						end
						K_MUL: begin
							// Single product in the first stage, then carried.
							rem_s[g+1] <= (g == 0) ? quo_s[g] * dvs_s[g] : rem_s[g];
							quo_s[g+1] <= quo_s[g];
							cnt_s[g+1] <= cnt_s[g];
						end
						default: begin
							rem_s[g+1] <= rem_s[g];
							quo_s[g+1] <= quo_s[g];
							cnt_s[g+1] <= cnt_s[g];
						end
					endcase
				end
			end
		end
	endgenerate

	always_comb begin
		unique case (d_s[Steps].kind)
			K_DIV: begin
				if (d_s[Steps].is_rem)
					fin = d_s[Steps].neg_r ? 32'd0 - rem_s[Steps] : rem_s[Steps];
				else
					fin = d_s[Steps].neg_q ? 32'd0 - quo_s[Steps] : quo_s[Steps];
			end
			K_POW, K_MUL: fin = rem_s[Steps];
			default: fin = d_s[Steps].value;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (adv) vld_q <= v_s[Steps];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= fin;
			null_q <= d_s[Steps].is_null;
			st_q <= d_s[Steps].status;
		end
	end

	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata = {5'd0, st_q, null_q, res_q};

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed during stall");
	a_null_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'd0)
		else $error("null result with nonzero value");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");
endmodule

// ----- tb/nialu_checker.sv -----
// Checker for the null-aware integer ALU: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module nialu_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,
	output int          fail_count,
	output int          pending
);
	import nialu_pkg::*;

	typedef struct packed {
		logic [31:0] value;
		logic        is_null;
		status_t     status;
	} alu_result_t;

	alu_result_t results_due[$];

	function automatic logic [15:0] exact_pow_bound(input logic [4:0] e);
		case (e)
			5'd2: return 16'd46340;
			5'd3: return 16'd1290;
			5'd4: return 16'd215;
			5'd5: return 16'd73;
			5'd6: return 16'd35;
			5'd7: return 16'd21;
			5'd8: return 16'd14;
			5'd9: return 16'd10;
			5'd10: return 16'd8;
			5'd11: return 16'd7;
			5'd12, 5'd13: return 16'd5;
			5'd14, 5'd15: return 16'd4;
			5'd16, 5'd17, 5'd18, 5'd19: return 16'd3;
			default: return 16'd2;
		endcase
	endfunction

	function automatic alu_result_t compute_result(input logic [71:0] d);
		logic [4:0] op;
		logic signed [31:0] a, b;
		logic an, bn;
		int ta, tb, t;
		logic [31:0] ma, mb, r;
		alu_result_t res;
		op = d[4:0];
		a = d[36:5];
		an = d[37];
		b = d[69:38];
		bn = d[70];
		res = '{value: 32'd0, is_null: 1'b0, status: ST_OK};
		if (op <= OP_LXOR) begin
			ta = an ? -1 : (a != 0);
			tb = bn ? -1 : (b != 0);
			if (op == OP_LAND)
				t = (ta == 0 || tb == 0) ? 0 : ((ta < 0 || tb < 0) ? -1 : 1);
			else if (op == OP_LOR)
				t = (ta == 1 || tb == 1) ? 1 : ((ta < 0 || tb < 0) ? -1 : 0);
			else
				t = (ta < 0 || tb < 0) ? -1 : (ta ^ tb);
			if (t < 0) res.is_null = 1'b1;
			else res.value = t;
		end else if (op > OP_LAST) begin
			res.status = ST_BADOP;
		end else if (an || bn) begin
			res.is_null = 1'b1;
		end else begin
			ma = a[31] ? -a : a;
			mb = b[31] ? -b : b;
			case (opcode_t'(op))
				OP_ADD: res.value = a + b;
				OP_SUB: res.value = a - b;
				OP_MUL: res.value = a * b;
				OP_IDIV, OP_REM: begin
					if (b == 0) res.status = ST_DIVZERO;
					else if (op == OP_IDIV) res.value = (a[31] ^ b[31]) ? -(ma / mb) : ma / mb;
					else res.value = a[31] ? -(ma % mb) : ma % mb;
				end
				OP_POW: begin
					if (b == 0) res.value = 32'd1;
					else if (b[31]) res.status = ST_FLOAT;
					else if (a == 0 || a == 1) res.value = a;
					else if (a == -1) res.value = b[0] ? 32'hFFFFFFFF : 32'd1;
					else if (b == 1) res.value = a;
					else if (b > 30 || ma > exact_pow_bound(b[4:0])) res.status = ST_FLOAT;
					else begin
						r = 32'd1;
						for (int e = 0; e < b; e++) r = r * a;
						res.value = r;
					end
				end
				OP_EQ: res.value = (a == b);
				OP_NE: res.value = (a != b);
				OP_LE: res.value = (a <= b);
				OP_LT: res.value = (a < b);
				OP_GE: res.value = (a >= b);
				OP_GT: res.value = (a > b);
				OP_MIN: res.value = (a < b) ? a : b;
				OP_MAX: res.value = (b < a) ? a : b;
				OP_BAND: res.value = a & b;
				OP_BOR: res.value = a | b;
				default: res.value = a ^ b;
			endcase
		end
		return res;
	endfunction

	assign pending = results_due.size();

	always @(posedge clk or negedge arst_n) begin
		alu_result_t want, got;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				results_due.push_back(compute_result(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{value: m_axis_tdata[31:0], is_null: m_axis_tdata[32],
					status: status_t'(m_axis_tdata[34:33])};
				if (results_due.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result transaction %h", m_axis_tdata);
					fail_count <= fail_count + 1;
				end else begin
					want = results_due.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display("mismatch: expected value %h null %b status %s, got %h %b %s",
								want.value, want.is_null, want.status.name(),
								got.value, got.is_null, got.status.name());
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// ----- tb/tb_null_aware_integer_alu.sv -----
// Top of the testbench for the null-aware integer ALU: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module tb_null_aware_integer_alu;
	import nialu_pkg::*;

	localparam int IDLE_LIMIT = 5000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	int          fail_count;
	int          pending;
	int          quiet_cycles;
	bit          long_hold;

	null_aware_integer_alu dut (.*);

	nialu_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sends one transaction and waits for it to be taken.
	task automatic send_op(input logic [4:0] op, input logic [31:0] a, input logic an,
		input logic [31:0] b, input logic bn);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, bn, b, an, a, op};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic pause_sender(input int n);
		s_axis_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 3) - 1;
			1: return $urandom_range(0, 1) ? 32'h80000000 : 32'h7FFFFFFF;
			2: return $urandom_range(0, 40) - 20;
			3: return $urandom_range(0, 50000) - 25000;
			default: return $urandom;
		endcase
	endfunction

	// Receiver: random stalls, with one long hold-off requested by the sender.
	initial begin
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				m_axis_tready <= 1'b0;
				repeat (200) @(posedge clk);
				long_hold = 1'b0;
			end else if ($urandom_range(0, 99) < 30 && ($urandom_range(0, 9) > 2))
				m_axis_tready <= 1'b0;
			else
				m_axis_tready <= 1'b1;
		end
	end

	initial begin
		logic [4:0] op;
		logic [31:0] a, b;
		int burst;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		long_hold = 1'b0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items: logic truth values, edges of arithmetic and power, compare, min/max, bitwise and bad opcodes.
		send_op(OP_LAND, 32'd0, 1'b1, 32'd5, 1'b0);
		send_op(OP_LOR, 32'd7, 1'b0, 32'd0, 1'b1);
		send_op(OP_LXOR, 32'd1, 1'b1, 32'd1, 1'b0);
		send_op(OP_LXOR, 32'hFFFFFFFF, 1'b0, 32'd1, 1'b0);
		send_op(OP_ADD, 32'h7FFFFFFF, 1'b0, 32'd1, 1'b0);
		send_op(OP_SUB, 32'h80000000, 1'b0, 32'd1, 1'b1);
		send_op(OP_MUL, 32'h80000000, 1'b0, 32'hFFFFFFFF, 1'b0);
		send_op(OP_IDIV, 32'h80000000, 1'b0, 32'hFFFFFFFF, 1'b0);
		send_op(OP_REM, 32'h80000000, 1'b0, 32'hFFFFFFFF, 1'b0);
		send_op(OP_IDIV, 32'd9, 1'b0, 32'd0, 1'b0);
		send_op(OP_REM, -32'sd7, 1'b0, 32'd2, 1'b0);
		send_op(OP_POW, 32'd0, 1'b0, 32'd0, 1'b0);
		send_op(OP_POW, 32'hFFFFFFFF, 1'b0, 32'd31, 1'b0);
		send_op(OP_POW, 32'd5, 1'b0, 32'hFFFFFFFF, 1'b0);
		send_op(OP_POW, 32'd46340, 1'b0, 32'd2, 1'b0);
		send_op(OP_POW, 32'd46341, 1'b0, 32'd2, 1'b0);
		send_op(OP_POW, -32'sd2, 1'b0, 32'd30, 1'b0);
		send_op(OP_POW, 32'd2, 1'b0, 32'd31, 1'b0);
		send_op(OP_LE, 32'h80000000, 1'b0, 32'h7FFFFFFF, 1'b0);
		send_op(OP_MIN, 32'd4, 1'b0, 32'd4, 1'b0);
		send_op(OP_MAX, 32'h80000000, 1'b0, 32'd0, 1'b0);
		send_op(OP_BXOR, 32'hFFFFFFFF, 1'b0, 32'h0F0F0F0F, 1'b0);
		send_op(5'd20, 32'd1, 1'b0, 32'd1, 1'b0);
		send_op(5'd31, 32'd1, 1'b1, 32'd1, 1'b1);

		// Sender keeps offering during the long receiver hold-off.
		long_hold = 1'b1;
		for (int i = 0; i < 80; i++)
			send_op(5'($urandom_range(0, 31)), $urandom, 1'($urandom_range(0, 1)), $urandom,
				1'($urandom_range(0, 1)));

		// Drain fully before the random part.
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);

		for (int n = 0; n < 1000; n += burst) begin
			burst = $urandom_range(1, 20);
			for (int k = 0; k < burst; k++) begin
				op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(20, 31))
					: 5'($urandom_range(0, 19));
				a = pick_operand();
				b = (op == OP_POW) ? $urandom_range(0, 35) - 2 : pick_operand();
				if (op == OP_POW && $urandom_range(0, 3) == 0) b = pick_operand();
				send_op(op, a, $urandom_range(0, 9) == 0, b, $urandom_range(0, 9) == 0);
			end
			if ($urandom_range(0, 2) == 0)
				pause_sender($urandom_range(1, 40));
		end
		s_axis_tvalid <= 1'b0;
	end

	// Watchdog and verdict.
	initial begin
		quiet_cycles = 0;
		@(posedge arst_n);
		repeat (2000) @(posedge clk);
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (pending == 0 && !s_axis_tvalid && quiet_cycles > 60)
				break;
			if (quiet_cycles >= IDLE_LIMIT)
				break;
		end
		if (quiet_cycles < IDLE_LIMIT && fail_count == 0 && !m_axis_tvalid)
			$display("tb_null_aware_integer_alu: clean");
		else
			$display("tb_null_aware_integer_alu: errors");
		$finish;
	end

endmodule
